/* rtl/thr_pkg.sv */
// Shared types and constants for the timestamped history ring.
// Used by thr_div and timestamped_history_ring; depends on nothing else.
package thr_pkg;

    // Field widths of the stream items and of the working values
    localparam int TS_W      = 48;
    localparam int SCORE_W   = 8;
    localparam int CNT_W     = 7;
    localparam int DUR_W     = 16;
    localparam int RES_W     = 16;
    localparam int CMD_W     = 2;
    localparam int SPAN_W    = 26;
    localparam int IN_DATA_W = 128;

    // Bit positions of the fields inside the input tdata
    localparam int SCORE_LSB = 0;
    localparam int TS_LSB    = SCORE_LSB + SCORE_W;
    localparam int REQ_LSB   = TS_LSB + TS_W;
    localparam int DUR_LSB   = REQ_LSB + CNT_W;
    localparam int NOW_LSB   = DUR_LSB + DUR_W;

    // Command codes carried in the input tuser
    localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LATEST   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESAMPLE = 2'd2;

    // Fixed numbers of the behaviour
    localparam int                 MAX_POINTS    = 64;
    localparam int                 MS_PER_S      = 1000;
    localparam logic [SCORE_W-1:0] DEFAULT_SCORE = 8'd100;
    localparam logic [RES_W-1:0]   RES_RESET     = 16'd1000;

    // One slot of the history memory
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TS_W-1:0]    stamp;
    } slot_t;

    // Status and result of the span divider
    typedef struct packed {
        logic              done;
        logic [SPAN_W-1:0] quot;
        logic [CNT_W-1:0]  rem;
    } div_res_t;

endpackage

/* rtl/thr_div.sv */
// Iterative restoring divider for the resample step size (span / count).
// One quotient bit per cycle; depends on thr_pkg.
module thr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [thr_pkg::SPAN_W-1:0] dividend,
    input  logic [thr_pkg::CNT_W-1:0]  divisor,
    output thr_pkg::div_res_t         res
);

    localparam int STEP_W = $clog2(thr_pkg::SPAN_W + 1);

    logic [thr_pkg::SPAN_W-1:0] quot_reg;
    logic [thr_pkg::CNT_W-1:0]  rem_reg;
    logic [thr_pkg::CNT_W-1:0]  divisor_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       done_reg;

    logic [thr_pkg::CNT_W:0]    rem_shift;
    logic                       fits;
    logic [thr_pkg::CNT_W-1:0]  rem_next;
    logic [thr_pkg::SPAN_W-1:0] quot_next;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[thr_pkg::SPAN_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};
        rem_next  = fits ? thr_pkg::CNT_W'(rem_shift - {1'b0, divisor_reg})
                         : rem_shift[thr_pkg::CNT_W-1:0];
        quot_next = {quot_reg[thr_pkg::SPAN_W-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= STEP_W'(thr_pkg::SPAN_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
                done_reg <= (step_reg == STEP_W'(1));
            end
        end
    end

    // Quotient and remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;
    assign res.rem  = rem_reg;

endmodule

/* rtl/timestamped_history_ring.sv */
// Top level of the timestamped history ring: slot memory, command sequencer and output register.
// Depends on thr_pkg and thr_div.
//
//  Channel   Direction  Handshake            Carries
//  s_axis    in         tvalid / tready      command (tuser), push and query fields (tdata)
//  m_axis    out        tvalid / tready      point_score (tdata), point_last (tlast)
//  cfg       in         valid / ready        resolution_ms (data)
//
// A latest query scans up to 64 slots, with a wait state before each check, set by the
// registered read port of the slot memory.
// A resample first sets up the span, the cutoff and, in the serial divider, the step size; then
// every point sweeps the whole slot memory, one entry a cycle, before it is emitted.
// Reset needs no clearing pass: a fill count marks which slots have ever been written.
// A stalled output holds the sequencer at the next result; the input waits until the
// command is finished, while the last result may still sit in the output register.
module timestamped_history_ring #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata, from bit 0: score[7:0], timestamp_ms[55:8], req_count[62:56],
    // duration_s[78:63], now_ms[126:79], zero[127]
    input  logic [thr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [thr_pkg::CMD_W-1:0]     s_axis_tuser,
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: point_score[7:0]
    output logic [thr_pkg::SCORE_W-1:0]   m_axis_tdata,
    // tlast: point_last
    output logic                          m_axis_tlast,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [thr_pkg::RES_W-1:0]     cfg_data
);

    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW       = $clog2(DEPTH + 1);
    localparam int IW       = AW + 8;
    localparam int MAX_LAT  = (DEPTH < thr_pkg::MAX_POINTS) ? DEPTH : thr_pkg::MAX_POINTS;
    localparam int TS_W     = thr_pkg::TS_W;
    localparam int CNT_W    = thr_pkg::CNT_W;
    localparam int SPAN_W   = thr_pkg::SPAN_W;
    localparam int SCORE_W  = thr_pkg::SCORE_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_LAT_INIT,
        ST_LAT_WAIT,
        ST_LAT_CHK,
        ST_LAT_FLUSH,
        ST_RS_SPAN,
        ST_RS_CUT,
        ST_RS_DIV,
        ST_RS_TGT,
        ST_RS_SCAN,
        ST_RS_DRAIN1,
        ST_RS_DRAIN2,
        ST_RS_EMIT
    } state_t;

    // Slot memory
    thr_pkg::slot_t             mem [DEPTH];
    thr_pkg::slot_t             rd_data_reg;

    // Control state
    state_t                     state_reg;
    logic [AW-1:0]              wptr_reg;
    logic [FW-1:0]              fill_reg;
    logic [TS_W-1:0]            last_update_reg;
    logic [thr_pkg::RES_W-1:0]  resolution_reg;
    logic                       out_valid_reg;
    logic                       pend_valid_reg;

    // Captured command fields and working values
    logic [SCORE_W-1:0]         score_reg;
    logic [TS_W-1:0]            ts_reg;
    logic [thr_pkg::DUR_W-1:0]  dur_reg;
    logic [TS_W-1:0]            now_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           idx_cnt_reg;
    logic [AW-1:0]              addr_reg;
    logic [SCORE_W-1:0]         pend_score_reg;
    logic [SCORE_W-1:0]         out_score_reg;
    logic                       out_last_reg;
    logic [SPAN_W-1:0]          span_reg;
    logic [TS_W-1:0]            cutoff_reg;
    logic [TS_W-1:0]            target_reg;
    logic [SPAN_W-1:0]          qs_reg;
    logic [CNT_W-1:0]           rs_reg;
    logic [SPAN_W-1:0]          q_acc_reg;
    logic [CNT_W-1:0]           r_acc_reg;

    // Resample scan pipeline
    logic                       s1_ok_reg;
    logic                       s2_qual_reg;
    logic [TS_W-1:0]            s2_diff_reg;
    logic [SCORE_W-1:0]         s2_score_reg;
    logic                       found_reg;
    logic [TS_W-1:0]            best_diff_reg;
    logic [SCORE_W-1:0]         best_score_reg;

    // Input field views
    logic [thr_pkg::CMD_W-1:0]  in_cmd;
    logic [SCORE_W-1:0]         in_score;
    logic [TS_W-1:0]            in_ts;
    logic [CNT_W-1:0]           in_req;
    logic [thr_pkg::DUR_W-1:0]  in_dur;
    logic [TS_W-1:0]            in_now;

    // Combinational helpers
    logic                       out_free;
    logic                       out_load;
    logic                       push_drop;
    logic                       mem_we;
    logic [CNT_W-1:0]           lat_n;
    logic [CNT_W-1:0]           rs_n;
    logic [IW-1:0]              lat_sum;
    logic [AW-1:0]              lat_start;
    logic [AW-1:0]              addr_inc;
    logic                       slot_ok;
    logic                       lat_hit;
    logic                       cnt_last;
    logic [CNT_W:0]             r_sum;
    logic                       r_wrap;
    logic [CNT_W-1:0]           r_acc_next;
    logic [SPAN_W-1:0]          q_acc_next;
    logic [TS_W:0]              diff_fwd;
    logic [TS_W-1:0]            diff_bwd;
    logic [TS_W-1:0]            diff_abs;
    logic                       s2_qual_next;
    logic                       div_start;
    thr_pkg::div_res_t          div_res;

    // Unpack the input transfer.
    assign in_cmd   = s_axis_tuser;
    assign in_score = s_axis_tdata[thr_pkg::SCORE_LSB +: SCORE_W];
    assign in_ts    = s_axis_tdata[thr_pkg::TS_LSB +: TS_W];
    assign in_req   = s_axis_tdata[thr_pkg::REQ_LSB +: CNT_W];
    assign in_dur   = s_axis_tdata[thr_pkg::DUR_LSB +: thr_pkg::DUR_W];
    assign in_now   = s_axis_tdata[thr_pkg::NOW_LSB +: TS_W];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_score_reg;
    assign m_axis_tlast  = out_last_reg;
    assign cfg_ready     = 1'b1;

    assign out_free = !out_valid_reg || m_axis_tready;

    // The output register takes a new point whenever the sequencer hands one over.
    assign out_load = ((state_reg == ST_LAT_CHK) && lat_hit && pend_valid_reg && out_free)
                   || ((state_reg == ST_LAT_FLUSH) && pend_valid_reg && out_free)
                   || ((state_reg == ST_RS_EMIT) && out_free);

    // Counts: a latest query of zero or more than the ring reads the whole ring, capped.
    assign lat_n = ((in_req == '0) || (in_req > CNT_W'(MAX_LAT))) ? CNT_W'(MAX_LAT) : in_req;
    assign rs_n  = (in_req > CNT_W'(thr_pkg::MAX_POINTS)) ? CNT_W'(thr_pkg::MAX_POINTS)
                                                          : in_req;

    // Rate limit: drop a push that comes too soon after the last accepted one.
    assign push_drop = (last_update_reg != '0)
                    && (TS_W'(ts_reg - last_update_reg) < TS_W'(resolution_reg));
    assign mem_we    = (state_reg == ST_PUSH) && !push_drop;

    // First slot of a latest scan: write pointer minus the count, modulo the depth.
    assign lat_sum   = IW'(wptr_reg) + IW'(DEPTH) - IW'(cnt_reg);
    assign lat_start = (lat_sum >= IW'(DEPTH)) ? AW'(lat_sum - IW'(DEPTH)) : AW'(lat_sum);
    assign addr_inc  = (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + AW'(1);

    // A slot counts only once written and when its timestamp is nonzero.
    assign slot_ok  = FW'(addr_reg) < fill_reg;
    assign lat_hit  = slot_ok && (rd_data_reg.stamp != '0);
    assign cnt_last = (idx_cnt_reg == cnt_reg - CNT_W'(1));

    // Next target offset: floor((i + 1) * span / count) kept as quotient and remainder.
    always_comb
    begin
        r_sum      = {1'b0, r_acc_reg} + {1'b0, rs_reg};
        r_wrap     = r_sum >= {1'b0, cnt_reg};
        r_acc_next = r_wrap ? CNT_W'(r_sum - {1'b0, cnt_reg}) : r_sum[CNT_W-1:0];
        q_acc_next = q_acc_reg + qs_reg + SPAN_W'(r_wrap);
    end

    // Distance of the slot read from the current target.
    always_comb
    begin
        diff_fwd     = {1'b0, rd_data_reg.stamp} - {1'b0, target_reg};
        diff_bwd     = target_reg - rd_data_reg.stamp;
        diff_abs     = diff_fwd[TS_W] ? diff_bwd : diff_fwd[TS_W-1:0];
        s2_qual_next = s1_ok_reg && (rd_data_reg.stamp != '0)
                    && (rd_data_reg.stamp >= cutoff_reg);
    end

    assign div_start = (state_reg == ST_RS_CUT);

    thr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (span_reg),
        .divisor  (cnt_reg),
        .res      (div_res)
    );

    // Slot memory: one write port for pushes, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wptr_reg] <= '{score: score_reg, stamp: ts_reg};
        end
        rd_data_reg <= mem[addr_reg];
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= thr_pkg::RES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            resolution_reg <= cfg_data;
        end
    end

    // Resample scan pipeline: qualify and measure, then keep the nearest slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ok_reg   <= 1'b0;
            s2_qual_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            s1_ok_reg   <= (state_reg == ST_RS_SCAN) && slot_ok;
            s2_qual_reg <= s2_qual_next;
            if (state_reg == ST_RS_TGT)
            begin
                found_reg <= 1'b0;
            end
            else if (s2_qual_reg && (!found_reg || (s2_diff_reg < best_diff_reg)))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_diff_reg  <= diff_abs;
        s2_score_reg <= rd_data_reg.score;
        if (s2_qual_reg && (!found_reg || (s2_diff_reg < best_diff_reg)))
        begin
            best_diff_reg  <= s2_diff_reg;
            best_score_reg <= s2_score_reg;
        end
    end

    // Command sequencer with the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            wptr_reg        <= '0;
            fill_reg        <= '0;
            last_update_reg <= '0;
            out_valid_reg   <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        score_reg <= in_score;
                        ts_reg    <= in_ts;
                        dur_reg   <= in_dur;
                        now_reg   <= in_now;
                        unique case (in_cmd)
                            thr_pkg::CMD_PUSH:
                            begin
                                state_reg <= ST_PUSH;
                            end
                            thr_pkg::CMD_LATEST:
                            begin
                                cnt_reg   <= lat_n;
                                state_reg <= ST_LAT_INIT;
                            end
                            thr_pkg::CMD_RESAMPLE:
                            begin
                                cnt_reg <= rs_n;
                                if (in_req != '0)
                                begin
                                    state_reg <= ST_RS_SPAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_PUSH:
                begin
                    if (!push_drop)
                    begin
                        wptr_reg        <= (wptr_reg == AW'(DEPTH - 1)) ? '0
                                                                        : wptr_reg + AW'(1);
                        fill_reg        <= (fill_reg == FW'(DEPTH)) ? fill_reg
                                                                    : fill_reg + FW'(1);
                        last_update_reg <= ts_reg;
                    end
                    state_reg <= ST_IDLE;
                end

                ST_LAT_INIT:
                begin
                    addr_reg       <= lat_start;
                    idx_cnt_reg    <= '0;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_LAT_WAIT;
                end

                ST_LAT_WAIT:
                begin
                    state_reg <= ST_LAT_CHK;
                end

                // A found score waits in the pending register so that the last one can be
                // marked once the scan is over.
                ST_LAT_CHK:
                begin
                    if (!(lat_hit && pend_valid_reg && !out_free))
                    begin
                        if (lat_hit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_score_reg <= pend_score_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_score_reg <= rd_data_reg.score;
                            pend_valid_reg <= 1'b1;
                        end
                        if (cnt_last)
                        begin
                            state_reg <= ST_LAT_FLUSH;
                        end
                        else
                        begin
                            addr_reg    <= addr_inc;
                            idx_cnt_reg <= idx_cnt_reg + CNT_W'(1);
                            state_reg   <= ST_LAT_WAIT;
                        end
                    end
                end

                ST_LAT_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_score_reg  <= pend_score_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                ST_RS_SPAN:
                begin
                    span_reg  <= SPAN_W'(dur_reg) * SPAN_W'(thr_pkg::MS_PER_S);
                    state_reg <= ST_RS_CUT;
                end

                ST_RS_CUT:
                begin
                    cutoff_reg <= now_reg - TS_W'(span_reg);
                    state_reg  <= ST_RS_DIV;
                end

                ST_RS_DIV:
                begin
                    if (div_res.done)
                    begin
                        qs_reg      <= div_res.quot;
                        rs_reg      <= div_res.rem;
                        q_acc_reg   <= '0;
                        r_acc_reg   <= '0;
                        idx_cnt_reg <= '0;
                        state_reg   <= ST_RS_TGT;
                    end
                end

                ST_RS_TGT:
                begin
                    target_reg <= cutoff_reg + TS_W'(q_acc_reg);
                    addr_reg   <= '0;
                    state_reg  <= ST_RS_SCAN;
                end

                ST_RS_SCAN:
                begin
                    if (addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_RS_DRAIN1;
                    end
                    else
                    begin
                        addr_reg <= addr_inc;
                    end
                end

                ST_RS_DRAIN1:
                begin
                    state_reg <= ST_RS_DRAIN2;
                end

                ST_RS_DRAIN2:
                begin
                    state_reg <= ST_RS_EMIT;
                end

                ST_RS_EMIT:
                begin
                    if (out_free)
                    begin
                        out_score_reg <= found_reg ? best_score_reg : thr_pkg::DEFAULT_SCORE;
                        out_last_reg  <= cnt_last;
                        q_acc_reg     <= q_acc_next;
                        r_acc_reg     <= r_acc_next;
                        idx_cnt_reg   <= idx_cnt_reg + CNT_W'(1);
                        state_reg     <= cnt_last ? ST_IDLE : ST_RS_TGT;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The fill count follows the write pointer until the ring has wrapped once.
    a_fill_tracks_wptr: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FW'(DEPTH)) |-> (FW'(wptr_reg) == fill_reg))
        else $error("fill count and write pointer disagree");

    // No held score may be left behind when a new command can be taken.
    a_no_pending_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_valid_reg)
        else $error("pending latest score left over at idle");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_RS_DIV))
        else $error("divider finished outside its wait state");

    // A resample never emits more points than were asked for.
    a_point_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RS_EMIT) |-> (idx_cnt_reg < cnt_reg))
        else $error("resample point index beyond the requested count");

endmodule
